### hdl/fchk_pkg.sv
// ----------------------------------------------------------------------------
// fchk_pkg: shared types and constants of the frame checker
// Register indexes, status codes, header layout and the channel structs.
// ----------------------------------------------------------------------------
package fchk_pkg;

  // header layout
  localparam int unsigned HEADER_BYTES = 16;

  // byte counter of one frame, saturating
  localparam int unsigned POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // crc-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MAGIC   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TYPE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD      = 8'd3;

  // register reset values
  localparam logic [31:0] RST_MAGIC       = 32'd0;
  localparam logic [7:0]  RST_VERSION     = 8'd1;
  localparam logic [7:0]  RST_TYPE        = 8'd1;
  localparam logic [15:0] RST_MAX_PAYLOAD = 16'd4096;

  // result item kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // frame status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_HDR = 2'd1;
  localparam logic [1:0] STATUS_BAD_CRC = 2'd2;

  typedef struct packed {
    logic [31:0] magic;
    logic [7:0]  version;
    logic [7:0]  frame_type;
    logic [15:0] max_payload;
  } fchk_cfg_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  frame_status;
    logic [15:0] payload_length;
  } fchk_result_t;

endpackage

### hdl/fchk_frame_state.sv
// ----------------------------------------------------------------------------
// fchk_frame_state: per-frame state and byte processing
// Tracks the header fields, the running crc and the received crc, and forms
// the result item for each byte in a single pass.
// ----------------------------------------------------------------------------
module fchk_frame_state
  import fchk_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  input  logic         rx_end,
  input  fchk_cfg_t    cfg,
  output logic         res_valid,
  output fchk_result_t res
);

  localparam logic [POS_W-1:0] POS_VERSION = POS_W'(4);
  localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(5);
  localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(13);
  localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(14);
  localparam logic [POS_W-1:0] HDR_LEN     = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] CRC_LEN     = POS_W'(4);

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      magic_r, magic_nxt;
  logic [7:0]       ver_r, ver_nxt;
  logic [7:0]       typ_r, typ_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [31:0]      crc_rx_r, crc_rx_nxt;
  logic             bad_r, bad_nxt;

  logic [POS_W-1:0] data_end;
  logic [POS_W-1:0] tail_off;
  logic             in_data;
  logic             in_tail;
  logic             is_payload;
  logic             hdr_bad;
  logic [1:0]       status;

  always_comb begin
    magic_nxt = magic_r;
    ver_nxt   = ver_r;
    typ_nxt   = typ_r;
    len_nxt   = len_r;
    // magic bytes little-endian in the first four positions
    if (pos_r[POS_W-1:2] == '0) begin
      magic_nxt = magic_r | ({24'd0, rx_byte} << {pos_r[1:0], 3'b000});
    end
    if (pos_r == POS_VERSION) ver_nxt = rx_byte;
    if (pos_r == POS_TYPE)    typ_nxt = rx_byte;
    if (pos_r == POS_LEN_LO)  len_nxt = {len_r[15:8], rx_byte};
    if (pos_r == POS_LEN_HI)  len_nxt = {rx_byte, len_r[7:0]};

    data_end   = HDR_LEN + {1'b0, len_nxt};
    in_data    = pos_r < data_end;
    tail_off   = pos_r - data_end;
    in_tail    = !in_data && (tail_off[POS_W-1:2] == '0);
    is_payload = in_data && (pos_r >= HDR_LEN);

    crc_nxt    = in_data ? crc_byte(crc_r, rx_byte) : crc_r;
    crc_rx_nxt = crc_rx_r;
    if (in_tail) begin
      crc_rx_nxt = crc_rx_r | ({24'd0, rx_byte} << {tail_off[1:0], 3'b000});
    end

    pos_nxt = pos_r;
    bad_nxt = bad_r;
    if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      bad_nxt = 1'b1;
    end

    hdr_bad = bad_nxt
           || (magic_nxt != cfg.magic)
           || (ver_nxt != cfg.version)
           || (typ_nxt != cfg.frame_type)
           || (len_nxt > cfg.max_payload)
           || (pos_nxt != (data_end + CRC_LEN));
    if (hdr_bad) begin
      status = STATUS_BAD_HDR;
    end else if (~crc_nxt != crc_rx_nxt) begin
      status = STATUS_BAD_CRC;
    end else begin
      status = STATUS_OK;
    end

    res_valid          = rx_end || is_payload;
    res.item_kind      = rx_end ? KIND_STATUS : KIND_PAYLOAD;
    res.payload_byte   = rx_end ? 8'd0 : rx_byte;
    res.frame_status   = rx_end ? status : STATUS_OK;
    res.payload_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && rx_end)) begin
      pos_r    <= '0;
      crc_r    <= CRC_INIT;
      magic_r  <= '0;
      ver_r    <= '0;
      typ_r    <= '0;
      len_r    <= '0;
      crc_rx_r <= '0;
      bad_r    <= 1'b0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      magic_r  <= magic_nxt;
      ver_r    <= ver_nxt;
      typ_r    <= typ_nxt;
      len_r    <= len_nxt;
      crc_rx_r <= crc_rx_nxt;
      bad_r    <= bad_nxt;
    end
  end

endmodule

### hdl/frame_checker_crc32_core.sv
// ----------------------------------------------------------------------------
// frame_checker_crc32_core: byte-serial frame checker with crc-32
// Checks header, length and trailing crc of a received frame and passes the
// image bytes on.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   one frame byte per item, in_rx_end high on the final byte
//   out_*  one item per image byte (kind payload), and one status item on
//          the final byte of each frame (kind status)
//   cfg_*  register writes, always ready; write only while the block is idle
// Header, crc field and trailing bytes give no item of their own.
// Path: an accepted item is held in the input register, and its result is
// written into the output register, which drives out_valid.
// Throughput: one byte per cycle; the input register and output register
// each take a new item every cycle while out_ready is high. The byte-wide
// crc update and the status compare sit between these two registers.
// Stall: when out_ready is low the output item holds, the input register
// fills, and in_ready drops until the output is taken.
// Reset: frame state clears, registers take magic 0, version 1, type 1,
// max payload 4096. After each final byte the frame state clears again.
// ----------------------------------------------------------------------------
module frame_checker_crc32_core
  import fchk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // byte input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 in_rx_end,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_item_kind,
  output logic [7:0]           out_payload_byte,
  output logic [1:0]           out_frame_status,
  output logic [15:0]          out_payload_length,
  // register write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // configuration registers
  fchk_cfg_t cfg_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // output register
  logic         out_valid_r;
  fchk_result_t out_r;

  logic         out_free;
  logic         s1_go;
  logic         in_acc;
  logic         res_valid;
  fchk_result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic       <= RST_MAGIC;
      cfg_r.version     <= RST_VERSION;
      cfg_r.frame_type  <= RST_TYPE;
      cfg_r.max_payload <= RST_MAX_PAYLOAD;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_EXPECTED_MAGIC:   cfg_r.magic       <= cfg_data;
        CFG_EXPECTED_VERSION: cfg_r.version     <= cfg_data[7:0];
        CFG_EXPECTED_TYPE:    cfg_r.frame_type  <= cfg_data[7:0];
        CFG_MAX_PAYLOAD:      cfg_r.max_payload <= cfg_data[15:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // the held byte moves on whenever the output register can take its result
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_rx_byte;
      s1_end_r  <= in_rx_end;
    end
  end

  // header tracking, crc and status for the held byte
  fchk_frame_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .rx_byte   (s1_byte_r),
    .rx_end    (s1_end_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_item_kind      = out_r.item_kind;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_frame_status   = out_r.frame_status;
  assign out_payload_length = out_r.payload_length;

  // a status item carries no image byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.item_kind == KIND_STATUS) |-> out_r.payload_byte == 8'd0)
    else $error("status item with non-zero payload byte");

  // a payload item always reports ok status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.item_kind == KIND_PAYLOAD) |-> out_r.frame_status == STATUS_OK)
    else $error("payload item with non-ok status");

  // status code is one of the defined ones
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.frame_status == STATUS_OK)
                 || (out_r.frame_status == STATUS_BAD_HDR)
                 || (out_r.frame_status == STATUS_BAD_CRC))
    else $error("undefined frame status");

  // a held byte waiting on a full output stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_end_r))
    else $error("input register lost its byte while stalled");

endmodule
